>>> hw/rtl/mm_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and arithmetic helpers for the matrix multiply block
package mm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = 4;
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  localparam int FUNC_W  = 2;
  localparam int REG_W   = 2;
  localparam int TDATA_W = ((ADDR_W + DATA_WIDTH + 7) / 8) * 8;

  // item kinds carried in tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // tag that travels with each read pair through the pipeline
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last_k;
    logic              last;
    logic [ADDR_W-1:0] pos;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // floor shift by the fraction width, then clip to the data range
  function automatic logic [DATA_WIDTH-1:0] saturate(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> FRAC_BITS;
    if (sh > SAT_MAX) begin
      return SAT_MAX[DATA_WIDTH-1:0];
    end else if (sh < SAT_MIN) begin
      return SAT_MIN[DATA_WIDTH-1:0];
    end
    return sh[DATA_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/mm_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mm_seq.sv
`timescale 1ns / 1ps
// address sequencer: walks rows, columns and the inner sum, one read pair per cycle while adv is high
module mm_seq
  import mm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIM_W-1:0]  left_rows,
  input  logic [DIM_W-1:0]  inner_size,
  input  logic [DIM_W-1:0]  right_cols,
  input  logic              adv,
  output logic              busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] left_addr,
  output logic [ADDR_W-1:0] right_addr,
  output tag_t              tag
);

  logic              running;
  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  c;
  logic [CNT_W-1:0]  k;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] ri;
  logic [ADDR_W-1:0] pos;

  logic [DIM_W-1:0]  rows_c;
  logic [DIM_W-1:0]  inner_c;
  logic [DIM_W-1:0]  cols_c;
  logic [CNT_W-1:0]  rows_m1;
  logic [CNT_W-1:0]  inner_m1;
  logic [CNT_W-1:0]  cols_m1;
  logic              k_last;
  logic              c_last;
  logic              r_last;

  always_comb begin
    rows_c   = clamp_dim(left_rows);
    inner_c  = clamp_dim(inner_size);
    cols_c   = clamp_dim(right_cols);
    rows_m1  = CNT_W'(rows_c - DIM_W'(1));
    inner_m1 = CNT_W'(inner_c - DIM_W'(1));
    cols_m1  = CNT_W'(cols_c - DIM_W'(1));
    k_last   = (k == inner_m1);
    c_last   = (c == cols_m1);
    r_last   = (r == rows_m1);
  end

  assign busy       = running;
  assign rd_en      = running && adv;
  assign left_addr  = row_base + ADDR_W'(k);
  assign right_addr = ri;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start && !running) begin
      running  <= 1'b1;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      row_base <= '0;
      ri       <= '0;
      pos      <= '0;
    end else if (running && adv) begin
      if (!k_last) begin
        k  <= k + CNT_W'(1);
        ri <= ri + ADDR_W'(cols_c);
      end else begin
        k   <= '0;
        pos <= pos + ADDR_W'(1);
        if (!c_last) begin
          c  <= c + CNT_W'(1);
          ri <= ADDR_W'(c) + ADDR_W'(1);
        end else begin
          c  <= '0;
          ri <= '0;
          if (r_last) begin
            running <= 1'b0;
          end else begin
            r        <= r + CNT_W'(1);
            row_base <= row_base + ADDR_W'(inner_c);
          end
        end
      end
    end
  end

  // tag is registered on the same adv as the ram read data, so the two line up
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (adv) begin
      tag.valid  <= running;
      tag.first  <= (k == '0);
      tag.last_k <= k_last;
      tag.last   <= k_last && c_last && r_last;
      tag.pos    <= pos;
    end
  end

endmodule

>>> hw/rtl/mm_mac.sv
`timescale 1ns / 1ps
// multiply, accumulate, saturate and output register
module mm_mac
  import mm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  tag_t                  tag_in,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_value,
  output logic [ADDR_W-1:0]     out_index,
  output logic                  out_last
);

  logic signed [PROD_W-1:0] prod;
  tag_t                     tag_p;
  logic signed [ACC_W-1:0]  acc;
  tag_t                     tag_a;
  logic signed [ACC_W-1:0]  prod_ext;

  // whole pipeline holds while a result waits at the output
  assign adv      = !out_valid || out_ready;
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= $signed(left_data) * $signed(right_data);
      if (tag_p.valid) begin
        acc <= tag_p.first ? prod_ext : acc + prod_ext;
      end
      if (tag_a.valid) begin
        out_value <= saturate(acc);
        out_index <= tag_a.pos;
        out_last  <= tag_a.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p     <= '0;
      tag_a     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      tag_p       <= tag_in;
      tag_a       <= tag_p;
      tag_a.valid <= tag_p.valid && tag_p.last_k;
      out_valid   <= tag_a.valid;
    end
  end

endmodule

>>> hw/rtl/matrix_multiply_top.sv
`timescale 1ns / 1ps
// top level of the fixed-point matrix multiply block
// Load items (left or right element) are taken one per cycle while no compute runs, and
// written straight into two 64 x 16 single-port-write rams. A compute item drops
// s_axis_tready and the sequencer issues one left/right read pair per cycle unless the
// output stalls, rows*cols*inner pairs in all (dimensions clamped to 1..8), through a
// multiply stage, an accumulate stage and a saturating output register. Input is taken
// again as soon as the last read pair has issued, so stores made then never collide
// with reads. A stalled output freezes the whole read pipeline.
module matrix_multiply_top
  import mm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // elem_index, elem_value, zero pad
  input  logic [FUNC_W-1:0]  s_axis_tuser,  // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // product_value, product_index, zero pad
  output logic               m_axis_tlast,
  input  logic               cfg_wr_en,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  logic [DIM_W-1:0]      left_rows;
  logic [DIM_W-1:0]      inner_size;
  logic [DIM_W-1:0]      right_cols;

  logic                  s_xfer;
  logic [ADDR_W-1:0]     elem_index;
  logic [DATA_WIDTH-1:0] elem_value;
  logic                  start;
  logic                  busy;
  logic                  adv;
  logic                  rd_en;
  logic [ADDR_W-1:0]     left_addr;
  logic [ADDR_W-1:0]     right_addr;
  logic [DATA_WIDTH-1:0] left_data;
  logic [DATA_WIDTH-1:0] right_data;
  tag_t                  tag;
  logic [DATA_WIDTH-1:0] product_value;
  logic [ADDR_W-1:0]     product_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= DIM_RESET;
      inner_size <= DIM_RESET;
      right_cols <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEFT_ROWS:  left_rows  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_RIGHT_COLS: right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign elem_index    = s_axis_tdata[ADDR_W-1:0];
  assign elem_value    = s_axis_tdata[ADDR_W+DATA_WIDTH-1:ADDR_W];
  assign start         = s_xfer && (s_axis_tuser == FUNC_COMPUTE);

  mm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk   (clk),
    .we    (s_xfer && (s_axis_tuser == FUNC_LOAD_LEFT)),
    .waddr (elem_index),
    .wdata (elem_value),
    .re    (rd_en),
    .raddr (left_addr),
    .rdata (left_data)
  );

  mm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk   (clk),
    .we    (s_xfer && (s_axis_tuser == FUNC_LOAD_RIGHT)),
    .waddr (elem_index),
    .wdata (elem_value),
    .re    (rd_en),
    .raddr (right_addr),
    .rdata (right_data)
  );

  mm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .left_rows  (left_rows),
    .inner_size (inner_size),
    .right_cols (right_cols),
    .adv        (adv),
    .busy       (busy),
    .rd_en      (rd_en),
    .left_addr  (left_addr),
    .right_addr (right_addr),
    .tag        (tag)
  );

  mm_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .left_data  (left_data),
    .right_data (right_data),
    .tag_in     (tag),
    .adv        (adv),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (product_value),
    .out_index  (product_index),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_W - ADDR_W - DATA_WIDTH){1'b0}}, product_index, product_value};

endmodule

>>> hw/rtl/mm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the matrix multiply top level, bound into it
module mm_checker
  import mm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [FUNC_W-1:0]  s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // input side closes only right after a compute transfer
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == FUNC_COMPUTE))
    else $error("input closed without a compute transfer");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("activity right after reset");

  // no result rises too soon after reset, before the pipeline can have filled
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(rst, 1) && !$past(rst, 2))
    else $error("result too soon after reset");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the fixed-point matrix multiply block
module tb;
  import mm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;   // unused item kind, ignored by the block
  localparam logic [REG_W-1:0]  REG_SPARE = 2'd3;   // index past the register list
  localparam int     LIMIT        = 2000000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     SETTLE       = 12;
  localparam int     RANDOM_ITEMS = 300;
  localparam int     PAD_W        = TDATA_W - ADDR_W - DATA_WIDTH;
  localparam longint VALUE_MAX    = 2 ** (DATA_WIDTH - 1) - 1;
  localparam longint VALUE_MIN    = -(2 ** (DATA_WIDTH - 1));

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [ADDR_W-1:0]     pos;
    logic [DATA_WIDTH-1:0] value;
  } elem_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [ADDR_W-1:0]     pos;
    logic                  last;
  } product_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [FUNC_W-1:0]  s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [REG_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data = '0;

  matrix_multiply_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the block: operand stores and dimension registers
  logic [DATA_WIDTH-1:0] left_mem [DEPTH];
  logic [DATA_WIDTH-1:0] right_mem [DEPTH];
  logic [DIM_W-1:0]      rows_reg  = DIM_RESET;
  logic [DIM_W-1:0]      inner_reg = DIM_RESET;
  logic [DIM_W-1:0]      cols_reg  = DIM_RESET;

  elem_item_t elem_queue [$];
  product_t   products_due [$];

  bit left_done [DEPTH];
  bit right_done [DEPTH];
  bit steady = 1'b0;
  bit counting = 1'b0;
  int rand_items = 0;
  int errors = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic int used_dim(logic [DIM_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end else if (raw > DIM_W'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  // expected product matrix in row-major order, exact sum then floor shift and clip
  task automatic predict_products();
    int rows, inner, cols;
    longint acc, q;
    product_t p;
    rows  = used_dim(rows_reg);
    inner = used_dim(inner_reg);
    cols  = used_dim(cols_reg);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        acc = 0;
        for (int k = 0; k < inner; k++) begin
          acc += longint'($signed(left_mem[(r * inner + k) % DEPTH])) *
                 longint'($signed(right_mem[(k * cols + c) % DEPTH]));
        end
        q = acc >>> FRAC_BITS;
        if (q > VALUE_MAX) begin
          p.value = DATA_WIDTH'(VALUE_MAX);
        end else if (q < VALUE_MIN) begin
          p.value = DATA_WIDTH'(VALUE_MIN);
        end else begin
          p.value = DATA_WIDTH'(q);
        end
        p.pos  = ADDR_W'(r * cols + c);
        p.last = (r == rows - 1) && (c == cols - 1);
        products_due.push_back(p);
      end
    end
  endtask

  // input side: update the shadow on every accepted transfer
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      case (s_axis_tuser)
        FUNC_LOAD_LEFT: begin
          left_mem[s_axis_tdata[ADDR_W-1:0]] = s_axis_tdata[ADDR_W +: DATA_WIDTH];
        end
        FUNC_LOAD_RIGHT: begin
          right_mem[s_axis_tdata[ADDR_W-1:0]] = s_axis_tdata[ADDR_W +: DATA_WIDTH];
        end
        FUNC_COMPUTE: begin
          predict_products();
        end
        default: begin
        end
      endcase
    end
  end

  // output side: compare each result with the oldest expected product
  always @(posedge clk) begin
    product_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[DATA_WIDTH-1:0];
      got.pos   = m_axis_tdata[DATA_WIDTH +: ADDR_W];
      got.last  = m_axis_tlast;
      if (products_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: result with none expected: value %h pos %0d last %0b",
                   got.value, got.pos, got.last);
        end
      end else begin
        want = products_due.pop_front();
        if (got.value !== want.value || got.pos !== want.pos || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display({"tb: mismatch: expected value %h pos %0d last %0b,",
                      " got value %h pos %0d last %0b"},
                     want.value, want.pos, want.last, got.value, got.pos, got.last);
          end
        end
      end
    end
  end

  // sender: next item only once the current one has transferred
  always @(posedge clk) begin
    elem_item_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (elem_queue.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
        item = elem_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.func;
        s_axis_tdata  <= {{PAD_W{1'b0}}, item.value, item.pos};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic put_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] pos,
                          logic [DATA_WIDTH-1:0] v);
    elem_queue.push_back('{f, pos, v});
    if (f == FUNC_LOAD_LEFT) begin
      left_done[pos] = 1'b1;
    end else if (f == FUNC_LOAD_RIGHT) begin
      right_done[pos] = 1'b1;
    end
    if (counting && f != FUNC_NONE) begin
      rand_items++;
    end
  endtask

  task automatic set_reg(logic [REG_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_LEFT_ROWS:  rows_reg = val;
      REG_INNER_SIZE: inner_reg = val;
      REG_RIGHT_COLS: cols_reg = val;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // wait until the block has taken everything and returned every product
  task automatic settle();
    while (elem_queue.size() != 0 || s_axis_tvalid || products_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) begin
      return DATA_WIDTH'($urandom);
    end else if (sel < 8) begin
      return DATA_WIDTH'($urandom_range(1023) - 512);
    end
    case ($urandom_range(3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) begin
      return DIM_W'($urandom_range(1, 4));
    end else if (sel < 8) begin
      return DIM_W'($urandom_range(1, MAX_DIM));
    end else if (sel == 8) begin
      return DIM_W'(MAX_DIM);
    end
    return $urandom_range(1) ? '0 : DIM_W'($urandom_range(MAX_DIM + 1, 15));
  endfunction

  // loads every operand the next compute reads that is still unwritten, plus a
  // random share of rewrites, shuffled, then the compute itself
  task automatic load_and_compute();
    elem_item_t batch [$];
    elem_item_t tmp;
    int n_left, n_right, j;
    n_left  = used_dim(rows_reg) * used_dim(inner_reg);
    n_right = used_dim(inner_reg) * used_dim(cols_reg);
    for (int i = 0; i < n_left; i++) begin
      if (!left_done[i] || $urandom_range(1)) begin
        batch.push_back('{FUNC_LOAD_LEFT, ADDR_W'(i), rand_value()});
      end
    end
    for (int i = 0; i < n_right; i++) begin
      if (!right_done[i] || $urandom_range(1)) begin
        batch.push_back('{FUNC_LOAD_RIGHT, ADDR_W'(i), rand_value()});
      end
    end
    for (int i = batch.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = batch[i];
      batch[i] = batch[j];
      batch[j] = tmp;
    end
    foreach (batch[i]) begin
      put_item(batch[i].func, batch[i].pos, batch[i].value);
    end
    put_item(FUNC_COMPUTE, ADDR_W'($urandom), DATA_WIDTH'($urandom));
  endtask

  task automatic run_phase(bit pressure);
    logic [DIM_W-1:0] r_raw, i_raw, c_raw;
    logic [FUNC_W-1:0] f;
    int computes;
    r_raw = pressure ? DIM_W'(MAX_DIM) : pick_dim();
    i_raw = pressure ? DIM_W'(MAX_DIM) : pick_dim();
    c_raw = pressure ? DIM_W'(MAX_DIM) : pick_dim();
    settle();
    steady = pressure;
    set_reg(REG_LEFT_ROWS, r_raw);
    set_reg(REG_INNER_SIZE, i_raw);
    set_reg(REG_RIGHT_COLS, c_raw);
    if ($urandom_range(3) == 0) begin
      set_reg(REG_SPARE, DIM_W'($urandom));
    end
    computes = pressure ? 2 : $urandom_range(1, 2);
    for (int n = 0; n < computes; n++) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(2))
          0: f = FUNC_LOAD_LEFT;
          1: f = FUNC_LOAD_RIGHT;
          default: f = FUNC_NONE;
        endcase
        put_item(f, ADDR_W'($urandom), DATA_WIDTH'($urandom));
      end
      load_and_compute();
    end
    if (pressure) begin
      // hold the output once the first product run is under way
      while (products_due.size() == 0) begin
        @(negedge clk);
      end
      hold_req++;
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 2x2x2 with full-scale operands: clipping both ways
    set_reg(REG_LEFT_ROWS, 4'd2);
    set_reg(REG_INNER_SIZE, 4'd2);
    set_reg(REG_RIGHT_COLS, 4'd2);
    set_reg(REG_SPARE, 4'hF);
    put_item(FUNC_LOAD_LEFT, 6'd0, 16'h7FFF);
    put_item(FUNC_LOAD_LEFT, 6'd1, 16'h7FFF);
    put_item(FUNC_LOAD_LEFT, 6'd2, 16'h8000);
    put_item(FUNC_LOAD_LEFT, 6'd3, 16'hFFFF);
    put_item(FUNC_LOAD_RIGHT, 6'd0, 16'h7FFF);
    put_item(FUNC_LOAD_RIGHT, 6'd1, 16'h8000);
    put_item(FUNC_LOAD_RIGHT, 6'd2, 16'h7FFF);
    put_item(FUNC_LOAD_RIGHT, 6'd3, 16'h0100);
    put_item(FUNC_NONE, 6'd63, 16'hFFFF);
    put_item(FUNC_COMPUTE, 6'd63, 16'hFFFF);
    // small negative sums: truncation rounds toward minus infinity
    put_item(FUNC_LOAD_LEFT, 6'd2, 16'h0000);
    put_item(FUNC_LOAD_LEFT, 6'd63, 16'h5555);
    put_item(FUNC_LOAD_RIGHT, 6'd63, 16'hAAAA);
    put_item(FUNC_COMPUTE, 6'd0, 16'h0000);

    // out-of-range dimension values clamp to 8x1x1
    settle();
    set_reg(REG_LEFT_ROWS, 4'd15);
    set_reg(REG_INNER_SIZE, 4'd0);
    set_reg(REG_RIGHT_COLS, 4'd0);
    put_item(FUNC_LOAD_LEFT, 6'd4, 16'h0080);
    put_item(FUNC_LOAD_LEFT, 6'd5, 16'hFF80);
    put_item(FUNC_LOAD_LEFT, 6'd6, 16'h1234);
    put_item(FUNC_LOAD_LEFT, 6'd7, 16'hEDCC);
    put_item(FUNC_COMPUTE, 6'd0, 16'h0000);

    counting = 1'b1;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      run_phase(phase == 1);
      phase++;
    end

    settle();
    errors += products_due.size();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
